// ----- hdl/lvf_pkg.sv -----
// Shared constants, coefficient table and control types for the luma vertical filter.
`timescale 1ns / 1ps

package lvf_pkg;

  localparam int LANES      = 8;
  localparam int IO_LANES   = 8;
  localparam int NUM_LANES  = (LANES < IO_LANES) ? LANES : IO_LANES;
  localparam int MAX_HEIGHT = 64;
  localparam int HIST_ROWS  = 7;
  localparam int TAPS       = 6;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int PIX_OFFSET = 257 << 11;
  localparam int PIX_SHIFT  = 12;
  localparam int RAW_SHIFT  = 6;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FILTER_PHASE = 2'd0;
  localparam logic [1:0] REG_RAW_OUTPUT   = 2'd1;
  localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd2;

  localparam logic [1:0] RST_FILTER_PHASE = 2'd1;
  localparam logic       RST_RAW_OUTPUT   = 1'b0;
  localparam logic [6:0] RST_BLOCK_HEIGHT = 7'd8;

  // Half-sample phase runs the symmetric eight-tap filter.
  localparam logic [1:0] PHASE_HALF = 2'd2;

  localparam logic [2:0] NEED_ROWS_8TAP = 3'd7;
  localparam logic [2:0] NEED_ROWS_7TAP = 3'd6;

  localparam logic signed [COEF_W-1:0] COEF_TAB [0:3][0:7] = '{
    '{ 8'sd0,  8'sd0,   8'sd0,  8'sd64,  8'sd0,   8'sd0,  8'sd0,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd10,  8'sd58,  8'sd17, -8'sd5,  8'sd1,  8'sd0},
    '{-8'sd1,  8'sd4, -8'sd11,  8'sd40,  8'sd40, -8'sd11, 8'sd4, -8'sd1},
    '{ 8'sd1, -8'sd5,  8'sd17,  8'sd58, -8'sd10,  8'sd4, -8'sd1,  8'sd0}
  };

  function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] phase,
                                                    input logic [2:0] idx);
    return COEF_TAB[phase][idx];
  endfunction

  typedef struct packed {
    logic       accept;   // input word taken: shift windows, load products
    logic       s2_load;  // product stage moves into the output register
    logic [1:0] phase;
    logic       raw;
  } lvf_ctl_t;

endpackage

// ----- hdl/luma_vertical_interp_filter.sv -----
// Top level of the luma vertical interpolation filter: control, lanes, output merge.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------------------
//   cfg     | in  | cfg_wr_en              | cfg_addr (register index), cfg_wr_data
//   in      | in  | in_tvalid / in_tready  | in_tuser = strip_start, in_tdata = 8 samples
//   out     | out | out_tvalid / out_tready| out_tlast = strip_end, out_tdata = 8 results
//
// One word per cycle sustained: every lane is fully pipelined, so input only waits
// while a result is held on out and the product stage behind it is full.
// A producing word is loaded into the product registers when it is accepted, then
// moves into the output register, where it is valid on out.
// Reset is synchronous, active low; it clears counters and valids and loads the
// register reset values (quarter phase, pixel output, height 8).
// A stalled output holds; the product stage still takes one more word behind it.
`timescale 1ns / 1ps

module luma_vertical_interp_filter (
  input  logic         clk,
  input  logic         rst_n,
  // configuration write port
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_addr,
  input  logic [6:0]   cfg_wr_data,
  // input rows
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // sample_l0 [15:0] .. sample_l7 [127:112]
  input  logic         in_tuser,   // strip_start
  // filtered rows
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // result_l0 [15:0] .. result_l7 [127:112]
  output logic         out_tlast   // strip_end
);

  lvf_pkg::lvf_ctl_t ctl;

  // Fill/emit bookkeeping and the valid chain live in one place; lanes only see
  // the load strobes and the current phase/mode.
  lvf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tuser    (in_tuser),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tlast   (out_tlast),
    .ctl         (ctl)
  );

  // Merge: each lane drives its own slice of the output word; lanes that are
  // not built read as zero.
  for (genvar g = 0; g < lvf_pkg::IO_LANES; g++) begin : g_lane
    if (g < lvf_pkg::NUM_LANES) begin : g_used
      lvf_lane u_lane (
        .clk    (clk),
        .ctl    (ctl),
        .sample (signed'(in_tdata[g*lvf_pkg::SAMPLE_W +: lvf_pkg::SAMPLE_W])),
        .result (out_tdata[g*lvf_pkg::SAMPLE_W +: lvf_pkg::SAMPLE_W])
      );
    end else begin : g_unused
      assign out_tdata[g*lvf_pkg::SAMPLE_W +: lvf_pkg::SAMPLE_W] = '0;
    end
  end

endmodule

// ----- hdl/lvf_lane.sv -----
// One column lane: row window, coefficient products and rounding/saturation.
`timescale 1ns / 1ps

module lvf_lane (
  input  logic                                  clk,
  input  lvf_pkg::lvf_ctl_t                     ctl,
  input  logic signed [lvf_pkg::SAMPLE_W-1:0]   sample,
  output logic        [lvf_pkg::SAMPLE_W-1:0]   result
);

  logic signed [lvf_pkg::SAMPLE_W-1:0] win_r    [lvf_pkg::HIST_ROWS];
  logic signed [lvf_pkg::SAMPLE_W-1:0] op       [lvf_pkg::TAPS];
  logic signed [lvf_pkg::COEF_W-1:0]   cf       [lvf_pkg::TAPS];
  logic signed [lvf_pkg::PROD_W-1:0]   prod_nxt [lvf_pkg::TAPS];
  logic signed [lvf_pkg::PROD_W-1:0]   prod_r   [lvf_pkg::TAPS];
  logic signed [lvf_pkg::SUM_W-1:0]    sum;
  logic signed [lvf_pkg::SUM_W-1:0]    raw_sh;
  logic signed [lvf_pkg::SUM_W-1:0]    pix_sum;
  logic signed [lvf_pkg::SUM_W-1:0]    pix_sh;
  logic        [lvf_pkg::SAMPLE_W-1:0] result_nxt;
  logic        [lvf_pkg::SAMPLE_W-1:0] result_r;

  // Window: entry 0 is the oldest row.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      for (int r = 0; r < lvf_pkg::HIST_ROWS - 1; r++) begin
        win_r[r] <= win_r[r + 1];
      end
      win_r[lvf_pkg::HIST_ROWS - 1] <= sample;
    end
  end

  // Pre-adds wrap at 16 bits on purpose.
  always_comb begin
    if (ctl.phase == lvf_pkg::PHASE_HALF) begin
      op[0] = win_r[0] + sample;
      op[1] = win_r[1] + win_r[6];
      op[2] = win_r[2] + win_r[5];
      op[3] = win_r[3] + win_r[4];
      op[4] = '0;
      op[5] = '0;
    end else begin
      op[0] = win_r[1] - sample;
      op[1] = win_r[2];
      op[2] = win_r[3];
      op[3] = win_r[4];
      op[4] = win_r[5];
      op[5] = win_r[6];
    end
    for (int k = 0; k < lvf_pkg::TAPS; k++) begin
      cf[k]       = lvf_pkg::coef(ctl.phase, 3'(k));
      prod_nxt[k] = op[k] * cf[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    sum = '0;
    for (int k = 0; k < lvf_pkg::TAPS; k++) begin
      sum = sum + {prod_r[k][lvf_pkg::PROD_W-1], prod_r[k]};
    end
    raw_sh  = sum >>> lvf_pkg::RAW_SHIFT;
    pix_sum = sum + lvf_pkg::SUM_W'(lvf_pkg::PIX_OFFSET);
    pix_sh  = pix_sum >>> lvf_pkg::PIX_SHIFT;
    if (ctl.raw) begin
      if (raw_sh > lvf_pkg::SUM_W'(32767)) begin
        result_nxt = 16'h7fff;
      end else if (raw_sh < -(lvf_pkg::SUM_W'(32768))) begin
        result_nxt = 16'h8000;
      end else begin
        result_nxt = raw_sh[lvf_pkg::SAMPLE_W-1:0];
      end
    end else begin
      if (pix_sh < 0) begin
        result_nxt = '0;
      end else if (pix_sh > lvf_pkg::SUM_W'(255)) begin
        result_nxt = 16'd255;
      end else begin
        result_nxt = {8'd0, pix_sh[7:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s2_load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

// ----- hdl/lvf_ctrl.sv -----
// Configuration registers, strip counters and pipeline valid/handshake control.
`timescale 1ns / 1ps

module lvf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_addr,
  input  logic [6:0]        cfg_wr_data,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic              out_tlast,
  output lvf_pkg::lvf_ctl_t ctl
);

  logic [1:0] phase_r;
  logic       raw_r;
  logic [6:0] height_cfg_r;
  logic [2:0] filled_r;
  logic [6:0] emitted_r;
  logic       s1_valid_r;
  logic       s1_end_r;
  logic       out_valid_r;
  logic       out_end_r;

  logic       out_adv;
  logic       accept;
  logic [2:0] filled_eff;
  logic [6:0] emitted_eff;
  logic [6:0] height;
  logic [2:0] need;
  logic       produce;
  logic       is_end;
  logic [2:0] filled_nxt;
  logic [6:0] emitted_nxt;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    filled_eff  = in_tuser ? '0 : filled_r;
    emitted_eff = in_tuser ? '0 : emitted_r;
    height      = ({1'b0, height_cfg_r} > 8'(lvf_pkg::MAX_HEIGHT)) ?
                  7'(lvf_pkg::MAX_HEIGHT) : height_cfg_r;
    need        = (phase_r == lvf_pkg::PHASE_HALF) ? lvf_pkg::NEED_ROWS_8TAP
                                                   : lvf_pkg::NEED_ROWS_7TAP;
    produce     = (filled_eff >= need) && (emitted_eff < height);
    is_end      = (emitted_eff + 7'd1) == height;
    filled_nxt  = (filled_eff == 3'(lvf_pkg::HIST_ROWS)) ? filled_eff : filled_eff + 3'd1;
    emitted_nxt = emitted_eff + {6'd0, produce};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= lvf_pkg::RST_FILTER_PHASE;
      raw_r        <= lvf_pkg::RST_RAW_OUTPUT;
      height_cfg_r <= lvf_pkg::RST_BLOCK_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        lvf_pkg::REG_FILTER_PHASE: phase_r      <= cfg_wr_data[1:0];
        lvf_pkg::REG_RAW_OUTPUT:   raw_r        <= cfg_wr_data[0];
        lvf_pkg::REG_BLOCK_HEIGHT: height_cfg_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      emitted_r   <= '0;
      s1_valid_r  <= 1'b0;
      s1_end_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      if (accept) begin
        filled_r  <= filled_nxt;
        emitted_r <= emitted_nxt;
      end
      if (in_tready) begin
        s1_valid_r <= accept && produce;
        s1_end_r   <= is_end;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
        out_end_r   <= s1_end_r;
      end
    end
  end

  assign out_tvalid  = out_valid_r;
  assign out_tlast   = out_end_r;
  assign ctl.accept  = accept;
  assign ctl.s2_load = out_adv && s1_valid_r;
  assign ctl.phase   = phase_r;
  assign ctl.raw     = raw_r;

endmodule

// ----- hdl/lvf_checker.sv -----
// Port-level checker for the luma vertical filter, bound to the top level.
`timescale 1ns / 1ps

module lvf_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic         out_tlast
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Empty output stage always leaves room for a new input word.
  a_ready_when_empty: assert property (@(posedge clk)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output is empty");

  // A new result only appears once an input word was taken and passed the product stage.
  a_out_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a preceding input word");

  // Reset drops the output valid.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind luma_vertical_interp_filter lvf_checker u_lvf_checker (.*);
